// ----- src/rdcw_pkg.sv -----
// rdcw_pkg: shared types and constants for the range distinct-count window block
// used by the channel interfaces, the sequencer, the count unit and the top level
package rdcw_pkg;

   localparam int POS_BITS        = 12;
   localparam int VALUE_IN_BITS   = 16;
   localparam int COUNT_BITS      = 13;
   localparam int DEF_ARRAY_DEPTH = 4096;
   localparam int DEF_VALUE_BITS  = 16;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLAN,
      S_ELEM,
      S_WAIT,
      S_WRITE,
      S_DONE
   } seq_state_type;

   // request to the count unit
   typedef struct packed {
      logic go;
      logic add;
   } cnt_ctl_type;

   // status back from the count unit
   typedef struct packed {
      logic busy;
      logic done;
      logic gained;
      logic lost;
   } cnt_sts_type;

endpackage

// ----- src/rdcw_if.sv -----
// rdcw_req_if / rdcw_rsp_if: valid/ready channels of the range distinct-count block
// depends on rdcw_pkg for field widths
interface rdcw_req_if import rdcw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [POS_BITS-1:0]      elem_index;
   logic [VALUE_IN_BITS-1:0] elem_value;
   logic [POS_BITS-1:0]      range_left;
   logic [POS_BITS-1:0]      range_right;

   modport source (output valid, opcode, elem_index, elem_value, range_left, range_right,
                   input ready);
   modport sink (input valid, opcode, elem_index, elem_value, range_left, range_right,
                 output ready);
endinterface

interface rdcw_rsp_if import rdcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] distinct_count;
   logic                  bad_range;

   modport source (output valid, distinct_count, bad_range, input ready);
   modport sink (input valid, distinct_count, bad_range, output ready);
endinterface

// ----- src/rdcw_elem_mem.sv -----
// rdcw_elem_mem: element array, one write port and one registered read port
// depends on rdcw_pkg
module rdcw_elem_mem import rdcw_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   localparam int ADDR_BITS  = $clog2(ARRAY_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] elem_mem [ARRAY_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         elem_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= elem_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rdcw_count_unit.sv -----
// rdcw_count_unit: per-value occurrence counts with a shared +1/-1 read-modify-write unit
// clears the count memory after reset; depends on rdcw_pkg
module rdcw_count_unit import rdcw_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int VALUE_SPAN = 1 << VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cnt_ctl_type           ctl,
   input  logic [VALUE_BITS-1:0] value,
   output cnt_sts_type           sts
);

   logic [COUNT_BITS-1:0] count_mem [VALUE_SPAN];
   logic [COUNT_BITS-1:0] rd_ff;
   logic [VALUE_BITS-1:0] addr_ff;
   logic                  add_ff;
   logic                  stage_ff;
   logic                  clearing_ff;
   logic                  clearing_in;
   logic [VALUE_BITS-1:0] clr_ff;
   logic [VALUE_BITS-1:0] clr_in;
   logic [COUNT_BITS-1:0] new_count;

   // a drop on a zero count leaves it at zero
   always_comb begin
      if (add_ff) begin
         new_count = COUNT_BITS'(rd_ff + 1'b1);
      end else if (rd_ff == '0) begin
         new_count = rd_ff;
      end else begin
         new_count = COUNT_BITS'(rd_ff - 1'b1);
      end
   end

   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = VALUE_BITS'(clr_ff + 1'b1);
         if (clr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         stage_ff    <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         stage_ff    <= ctl.go;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         count_mem[clr_ff] <= '0;
      end else if (stage_ff) begin
         count_mem[addr_ff] <= new_count;
      end
      rd_ff   <= count_mem[value];
      addr_ff <= value;
      add_ff  <= ctl.add;
   end

   assign sts.busy   = clearing_ff;
   assign sts.done   = stage_ff;
   assign sts.gained = stage_ff && add_ff && (new_count == COUNT_BITS'(1));
   assign sts.lost   = stage_ff && !add_ff && (rd_ff != '0) && (new_count == '0);

endmodule

// ----- src/rdcw_seq.sv -----
// rdcw_seq: window sequencer; steps the window ends one position at a time
// and drives the element memory and the count unit; depends on rdcw_pkg and rdcw_if
module rdcw_seq import rdcw_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   localparam int ADDR_BITS  = $clog2(ARRAY_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   rdcw_req_if.sink              req_ch,
   rdcw_rsp_if.source            rsp_ch,
   output logic                  elem_wr_en,
   output logic [ADDR_BITS-1:0]  elem_wr_addr,
   output logic [VALUE_BITS-1:0] elem_wr_data,
   output logic [ADDR_BITS-1:0]  elem_rd_addr,
   output cnt_ctl_type           cnt_ctl,
   input  cnt_sts_type           cnt_sts
);

   seq_state_type         state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [POS_BITS-1:0]   left_ff, left_in;
   logic [POS_BITS-1:0]   right_ff, right_in;
   logic [POS_BITS-1:0]   idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  bad_ff, bad_in;
   logic [POS_BITS-1:0]   lo_ff, lo_in;
   logic [POS_BITS-1:0]   hi_ff, hi_in;
   logic                  empty_ff, empty_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  add_ff, add_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      bad_in       = bad_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      empty_in     = empty_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      add_in       = add_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      req_ch.ready = 1'b0;
      elem_wr_en   = 1'b0;
      cnt_ctl      = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = !cnt_sts.busy;
            if (req_ch.valid && !cnt_sts.busy) begin
               op_in    = opcode_type'(req_ch.opcode);
               left_in  = req_ch.range_left;
               right_in = req_ch.range_right;
               idx_in   = req_ch.elem_index;
               val_in   = VALUE_BITS'(req_ch.elem_value);
               bad_in   = 1'b0;
               state_in = S_PLAN;
               if (opcode_type'(req_ch.opcode) == OP_QUERY &&
                   (req_ch.range_left > req_ch.range_right ||
                    32'(req_ch.range_right) >= ARRAY_DEPTH)) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_PLAN: begin
            state_in = S_ELEM;
            if (op_ff == OP_LOAD) begin
               // empty the window from its low end, one element per step
               if (empty_ff) begin
                  state_in = S_WRITE;
               end else begin
                  pos_in = lo_ff;
                  add_in = 1'b0;
                  if (lo_ff == hi_ff) begin
                     empty_in = 1'b1;
                     lo_in    = '0;
                     hi_in    = '0;
                  end else begin
                     lo_in = POS_BITS'(lo_ff + 1'b1);
                  end
               end
            end else begin
               // grow before shrinking so the window never runs empty
               priority if (empty_ff) begin
                  pos_in   = left_ff;
                  add_in   = 1'b1;
                  lo_in    = left_ff;
                  hi_in    = left_ff;
                  empty_in = 1'b0;
               end else if (hi_ff < right_ff) begin
                  pos_in = POS_BITS'(hi_ff + 1'b1);
                  add_in = 1'b1;
                  hi_in  = POS_BITS'(hi_ff + 1'b1);
               end else if (lo_ff > left_ff) begin
                  pos_in = POS_BITS'(lo_ff - 1'b1);
                  add_in = 1'b1;
                  lo_in  = POS_BITS'(lo_ff - 1'b1);
               end else if (hi_ff > right_ff) begin
                  pos_in = hi_ff;
                  add_in = 1'b0;
                  hi_in  = POS_BITS'(hi_ff - 1'b1);
               end else if (lo_ff < left_ff) begin
                  pos_in = lo_ff;
                  add_in = 1'b0;
                  lo_in  = POS_BITS'(lo_ff + 1'b1);
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ELEM: begin
            cnt_ctl.go  = 1'b1;
            cnt_ctl.add = add_ff;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            if (cnt_sts.done) begin
               if (cnt_sts.gained) begin
                  total_in = COUNT_BITS'(total_ff + 1'b1);
               end else if (cnt_sts.lost && total_ff != '0) begin
                  total_in = COUNT_BITS'(total_ff - 1'b1);
               end
               state_in = S_PLAN;
            end
         end
         S_WRITE: begin
            elem_wr_en = 32'(idx_ff) < ARRAY_DEPTH;
            total_in   = '0;
            lo_in      = '0;
            hi_in      = '0;
            empty_in   = 1'b1;
            state_in   = S_IDLE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = bad_ff ? '0 : total_ff;
               rsp_bad_in   = bad_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lo_ff        <= '0;
         hi_ff        <= '0;
         empty_ff     <= 1'b1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         empty_ff     <= empty_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      bad_ff       <= bad_in;
      pos_ff       <= pos_in;
      add_ff       <= add_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // element read is launched as the step is planned
   assign elem_rd_addr = ADDR_BITS'(pos_in);
   assign elem_wr_addr = ADDR_BITS'(idx_ff);
   assign elem_wr_data = val_ff;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.distinct_count = rsp_count_ff;
   assign rsp_ch.bad_range      = rsp_bad_ff;

endmodule

// ----- src/range_distinct_count_window.sv -----
// range_distinct_count_window_core: top level of the range distinct-count block
// depends on rdcw_pkg, rdcw_if, rdcw_elem_mem, rdcw_count_unit and rdcw_seq
//
// Usage:
//   req_ch carries items in, rsp_ch carries results out; both are valid/ready
//   channels and a transfer happens on a rising clock edge with valid and ready high.
//   A load item (opcode 0) empties the current window, then writes one element;
//   it produces no result. A query item (opcode 1) slides the window to
//   [range_left, range_right] and returns the number of distinct values in it.
//   A query with left above right, or right beyond the array, returns count 0
//   with bad_range set and leaves the window as it was.
// Timing:
//   each window step adds or drops one position: one element read plus one
//   read-modify-write of the count memory, through S_PLAN, S_ELEM and S_WAIT;
//   a query (on an empty window the first step adds range_left) ends in S_DONE,
//   a load takes one step per element of the current window, then S_WRITE.
//   One item is worked on at a time; req_ch.ready is high only while idle.
// Reset:
//   reset is synchronous; afterwards the count memory is cleared in a pass over
//   all 2^VALUE_BITS entries (65536 by default) with req_ch.ready held low.
// Stalls:
//   a result waits in the output register while rsp_ch.ready is low; the next
//   item is still taken, but its own result waits until the register frees up.
module range_distinct_count_window_core import rdcw_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input logic        clock,
   input logic        reset,
   rdcw_req_if.sink   req_ch,
   rdcw_rsp_if.source rsp_ch
);

   localparam int ADDR_BITS = $clog2(ARRAY_DEPTH);

   logic                  elem_wr_en;
   logic [ADDR_BITS-1:0]  elem_wr_addr;
   logic [VALUE_BITS-1:0] elem_wr_data;
   logic [ADDR_BITS-1:0]  elem_rd_addr;
   logic [VALUE_BITS-1:0] elem_rd_data;
   cnt_ctl_type           cnt_ctl;
   cnt_sts_type           cnt_sts;

   rdcw_seq #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .elem_wr_en   (elem_wr_en),
      .elem_wr_addr (elem_wr_addr),
      .elem_wr_data (elem_wr_data),
      .elem_rd_addr (elem_rd_addr),
      .cnt_ctl      (cnt_ctl),
      .cnt_sts      (cnt_sts)
   );

   rdcw_elem_mem #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_elem_mem (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   rdcw_count_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_count_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (cnt_ctl),
      .value (elem_rd_data),
      .sts   (cnt_sts)
   );

   // no item may enter while the count memory is still being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !cnt_sts.busy)
      else $error("item transfer during count memory clear");

   // each count update finishes in the following cycle
   a_count_done: assert property (@(posedge clock) disable iff (reset)
      cnt_ctl.go |=> cnt_sts.done)
      else $error("count update did not complete");

   // the count unit never sees a new request while a write-back is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cnt_sts.done |-> !cnt_ctl.go)
      else $error("overlapping count updates");

   // gaining and losing a distinct value are exclusive
   a_gain_lose: assert property (@(posedge clock) disable iff (reset)
      !(cnt_sts.gained && cnt_sts.lost))
      else $error("count unit reports gain and loss together");

endmodule
